>>> design/bfcr_pkg.sv
// Shared types and constants for the bitmap font character renderer.
// No dependencies; imported by the row engine and the top level.
package bfcr_pkg;

    // Default glyph store shape
    localparam int DEF_GLYPH_COUNT = 256;
    localparam int DEF_GLYPH_ROWS  = 16;

    // Fixed geometry of a character cell
    localparam int CELL_WIDTH = 8;
    localparam int DRAW_ROWS  = 16;
    localparam int LINE_STEP  = 16;

    // Field widths
    localparam int ADDR_W   = 48;
    localparam int PITCH_W  = 14;
    localparam int COLOR_W  = 32;
    localparam int CUR_X_W  = 13;
    localparam int CUR_Y_W  = 16;
    localparam int CFG_IDX_W = 2;

    // Width limit for the line wrap
    localparam logic [PITCH_W-1:0] WIDTH_CAP = 14'd8192;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    // Character codes
    localparam logic [7:0] NEWLINE_CODE = 8'd10;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_BASE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCANLINE_PITCH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR     = 2'd3;

    // Reset values of the configuration registers
    localparam logic [ADDR_W-1:0]  RST_FRAME_BASE     = 48'd0;
    localparam logic [PITCH_W-1:0] RST_SCANLINE_PITCH = 14'd1024;
    localparam logic [PITCH_W-1:0] RST_SCREEN_WIDTH   = 14'd1024;
    localparam logic [COLOR_W-1:0] RST_TEXT_COLOR     = 32'hFFFF_FFFF;

    // Input item
    typedef struct packed {
        logic       cmd;
        logic [7:0] char_code;
        logic [3:0] glyph_row;
        logic [7:0] glyph_bits;
    } item_t;

    // Result item: one glyph row write
    typedef struct packed {
        logic [ADDR_W-1:0]  pixel_address;
        logic [7:0]         pixel_mask;
        logic [COLOR_W-1:0] write_color;
        logic               last_row;
    } result_t;

    // Configuration as seen by the row engine
    typedef struct packed {
        logic [ADDR_W-1:0]  frame_base;
        logic [PITCH_W-1:0] scanline_pitch;
        logic [PITCH_W-1:0] screen_width;
        logic [COLOR_W-1:0] text_color;
    } cfg_t;

endpackage

>>> design/bfcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module bfcr_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_W-1:0]        wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_W-1:0]        rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data holds while rd_en is low
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> design/bfcr_engine.sv
// Row engine: glyph store, cursor, address generation and result register.
// Depends on bfcr_pkg and bfcr_ram.
module bfcr_engine #(
    parameter int GLYPH_COUNT = bfcr_pkg::DEF_GLYPH_COUNT,
    parameter int GLYPH_ROWS  = bfcr_pkg::DEF_GLYPH_ROWS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  bfcr_pkg::cfg_t    cfg,
    input  logic              s_valid,
    output logic              s_ready,
    input  bfcr_pkg::item_t   s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output bfcr_pkg::result_t m_item
);

    import bfcr_pkg::*;

    localparam int STORE_SIZE = GLYPH_COUNT * GLYPH_ROWS;
    localparam int IDX_W      = $clog2(STORE_SIZE);
    localparam int ROW_W      = $clog2(DRAW_ROWS);
    localparam int PROD_W     = CUR_Y_W + PITCH_W;
    localparam int OFS_W      = PROD_W + 1;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SETUP = 3'b010,
        ST_ROWS  = 3'b100
    } state_t;

    // Store entry of a glyph row; code wraps past the glyph count, and the
    // row may run into the next glyph, wrapping at the end of the store.
    function automatic logic [IDX_W-1:0] glyph_index(input logic [7:0] code,
                                                     input logic [ROW_W-1:0] row);
        logic [IDX_W:0] code_w;
        logic [IDX_W:0] sum_w;
        code_w = (IDX_W+1)'(code);
        if (code_w >= (IDX_W+1)'(GLYPH_COUNT)) begin
            code_w = code_w - (IDX_W+1)'(GLYPH_COUNT);
        end
        sum_w = code_w * (IDX_W+1)'(GLYPH_ROWS) + (IDX_W+1)'(row);
        if (sum_w >= (IDX_W+1)'(STORE_SIZE)) begin
            sum_w = sum_w - (IDX_W+1)'(STORE_SIZE);
        end
        return sum_w[IDX_W-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg;
    logic [ROW_W-1:0]    row_reg;
    logic [PROD_W-1:0]   prod_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [CUR_X_W-1:0]  cursor_x_reg;
    logic [CUR_Y_W-1:0]  cursor_y_reg;
    logic                m_valid_reg;
    result_t             m_item_reg;

    logic                accept;
    logic                is_draw;
    logic                is_newline;
    logic                start;
    logic                wr_en;
    logic                out_free;
    logic                load_row;
    logic                row_last;
    logic [IDX_W-1:0]    idx_inc;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;
    logic [7:0]          rd_data;
    logic [CUR_Y_W-1:0]  y_down;
    logic [CUR_Y_W:0]    y_sum;
    logic [PITCH_W-1:0]  sw_cap;
    logic [PITCH_W:0]    nx;
    logic                wrap;
    logic [OFS_W-1:0]    pix_ofs;

    // Input decode
    assign s_ready    = (state_reg == ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign wr_en      = accept && (s_item.cmd == CMD_LOAD);
    assign is_draw    = accept && (s_item.cmd == CMD_DRAW);
    assign is_newline = is_draw && (s_item.char_code == NEWLINE_CODE);
    assign start      = is_draw && (s_item.char_code != NEWLINE_CODE);

    // Row stepping: a row moves into the result register when it is free
    assign out_free = !m_valid_reg || m_ready;
    assign load_row = (state_reg == ST_ROWS) && out_free;
    assign row_last = (row_reg == ROW_W'(DRAW_ROWS - 1));
    assign idx_inc  = (idx_reg == IDX_W'(STORE_SIZE - 1)) ? '0 : idx_reg + 1'b1;

    // Read the first row in setup, the next one each time a row is taken
    assign rd_en   = (state_reg == ST_SETUP) || load_row;
    assign rd_addr = (state_reg == ST_SETUP) ? idx_reg : idx_inc;

    bfcr_ram #(
        .DATA_W (8),
        .DEPTH  (STORE_SIZE)
    ) u_glyph_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (glyph_index(s_item.char_code, s_item.glyph_row)),
        .wr_data (s_item.glyph_bits),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Cursor moves: line down with saturation, advance with wrap
    assign y_sum  = {1'b0, cursor_y_reg} + (CUR_Y_W+1)'(LINE_STEP);
    assign y_down = y_sum[CUR_Y_W] ? '1 : y_sum[CUR_Y_W-1:0];
    assign sw_cap = (cfg.screen_width > WIDTH_CAP) ? WIDTH_CAP : cfg.screen_width;
    assign nx     = (PITCH_W+1)'(cursor_x_reg) + (PITCH_W+1)'(CELL_WIDTH);
    assign wrap   = ((nx + (PITCH_W+1)'(CELL_WIDTH)) > (PITCH_W+1)'(sw_cap))
                    || nx[CUR_X_W];

    // Pixel offset of the cursor cell's top row
    assign pix_ofs = OFS_W'(prod_reg) + OFS_W'(cursor_x_reg);

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (start) state_next = ST_SETUP;
            ST_SETUP: state_next = ST_ROWS;
            ST_ROWS:  if (load_row && row_last) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Cursor
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
        end else if (is_newline || (load_row && row_last && wrap)) begin
            cursor_x_reg <= '0;
            cursor_y_reg <= y_down;
        end else if (load_row && row_last) begin
            cursor_x_reg <= nx[CUR_X_W-1:0];
        end
    end

    // Row index, glyph entry and framebuffer address
    always_ff @(posedge aclk) begin
        if (start) begin
            idx_reg  <= glyph_index(s_item.char_code, '0);
            prod_reg <= PROD_W'(cursor_y_reg) * PROD_W'(cfg.scanline_pitch);
        end else if (load_row) begin
            idx_reg <= idx_inc;
        end
        if (state_reg == ST_SETUP) begin
            row_reg  <= '0;
            addr_reg <= cfg.frame_base + ADDR_W'({pix_ofs, 2'b00});
        end else if (load_row) begin
            row_reg  <= row_reg + 1'b1;
            addr_reg <= addr_reg + ADDR_W'({cfg.scanline_pitch, 2'b00});
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (load_row) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_row) begin
            m_item_reg.pixel_address <= addr_reg;
            m_item_reg.pixel_mask    <= rd_data;
            m_item_reg.write_color   <= cfg.text_color;
            m_item_reg.last_row      <= row_last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> design/bitmap_font_char_renderer_core.sv
// Top level of the bitmap font character renderer: configuration registers
// and the row engine. Depends on bfcr_pkg and bfcr_engine.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  s_      | in        | s_valid / s_ready  | s_item  (cmd, code, row, bits)
//  m_      | out       | m_valid / m_ready  | m_item  (address, mask, colour)
//  cfg_    | in        | cfg_we             | cfg_index, cfg_wdata
//
// A load or a newline leaves the input ready. A drawn character passes
// through the cursor multiply and the first glyph store read, then gives
// one row per cycle from the glyph memory unless m_ready stalls; a stall
// holds the row stepping. The next item is taken while the last row still waits.
// Reset is synchronous, active low; the glyph store has no reset.
module bitmap_font_char_renderer_core #(
    parameter int GLYPH_COUNT = bfcr_pkg::DEF_GLYPH_COUNT,
    parameter int GLYPH_ROWS  = bfcr_pkg::DEF_GLYPH_ROWS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  bfcr_pkg::item_t                     s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output bfcr_pkg::result_t                   m_item,
    input  logic                                cfg_we,
    input  logic [bfcr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bfcr_pkg::ADDR_W-1:0]         cfg_wdata
);

    import bfcr_pkg::*;

    cfg_t cfg_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.frame_base     <= RST_FRAME_BASE;
            cfg_reg.scanline_pitch <= RST_SCANLINE_PITCH;
            cfg_reg.screen_width   <= RST_SCREEN_WIDTH;
            cfg_reg.text_color     <= RST_TEXT_COLOR;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_BASE:     cfg_reg.frame_base     <= cfg_wdata;
                REG_SCANLINE_PITCH: cfg_reg.scanline_pitch <= cfg_wdata[PITCH_W-1:0];
                REG_SCREEN_WIDTH:   cfg_reg.screen_width   <= cfg_wdata[PITCH_W-1:0];
                REG_TEXT_COLOR:     cfg_reg.text_color     <= cfg_wdata[COLOR_W-1:0];
                default:            ;
            endcase
        end
    end

    bfcr_engine #(
        .GLYPH_COUNT (GLYPH_COUNT),
        .GLYPH_ROWS  (GLYPH_ROWS)
    ) u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

`ifndef SYNTH
    // A drawn character blocks the input while its rows are produced
    a_draw_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.cmd == CMD_DRAW
         && s_item.char_code != NEWLINE_CODE) |=> !s_ready)
        else $error("input not blocked after a draw item");

    // Loads never stall the input
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_item.cmd == CMD_LOAD) |=> s_ready)
        else $error("input blocked after a load item");

    // A row other than the last is only shown while the character is in work
    a_row_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_item.last_row) |-> !s_ready)
        else $error("input open while a character is unfinished");
`endif

endmodule
